>>> src/gpd_pkg.sv
// Shared types and constants for the gameport packet decoder.
// Used by gpd_decoder, gpd_div and gameport_packet_decode_normalize.
`default_nettype none

package gpd_pkg;

  localparam int unsigned AXES     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CAL_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X1_CAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y1_CAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X2_CAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y2_CAL    = 3'd4;

  localparam logic [CAL_W-1:0] CAL_RESET = 24'h0080FF;

  typedef struct packed {
    logic [3:0]      buttons;
    logic [3:0][7:0] raw;
  } packet_t;

  typedef struct packed {
    logic       start;
    logic [7:0] num_mag;
    logic [7:0] den_mag;
  } div_req_t;

endpackage

`default_nettype wire

>>> src/gpd_decoder.sv
// Packet assembler: collects six serial words into raw axes and switches.
// Depends on gpd_pkg for packet_t.
`default_nettype none

module gpd_decoder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_accept,
  input  wire logic [7:0]      byte_in,
  output gpd_pkg::packet_t     pkt,
  output logic                 pkt_done
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_1    = 3'd1;
  localparam logic [2:0] PH_2    = 3'd2;
  localparam logic [2:0] PH_3    = 3'd3;
  localparam logic [2:0] PH_4    = 3'd4;
  localparam logic [2:0] PH_5    = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] ax0_r, ax0_nxt, ax1_r, ax1_nxt, ax2_r, ax2_nxt, ax3_r, ax3_nxt;
  logic [3:0] btn_r, btn_nxt;
  logic       start_bit;
  logic       mid_packet;

  assign start_bit  = byte_in[7];
  assign mid_packet = (phase_r >= PH_1) && (phase_r <= PH_5);

  always_comb begin
    phase_nxt = phase_r;
    ax0_nxt   = ax0_r;
    ax1_nxt   = ax1_r;
    ax2_nxt   = ax2_r;
    ax3_nxt   = ax3_r;
    btn_nxt   = btn_r;
    pkt_done  = 1'b0;
    if (byte_accept) begin
      if (mid_packet && start_bit) begin
        phase_nxt = PH_WAIT;
      end else begin
        case (phase_r)
          PH_1: begin
            ax0_nxt   = ax0_r + {3'b000, byte_in[6:2]};
            ax1_nxt   = {byte_in[1:0], 6'b000000};
            phase_nxt = PH_2;
          end
          PH_2: begin
            ax1_nxt   = ax1_r + {2'b00, byte_in[6:1]};
            ax2_nxt   = {byte_in[0], 7'b0000000};
            phase_nxt = PH_3;
          end
          PH_3: begin
            ax2_nxt   = ax2_r + {1'b0, byte_in[6:0]};
            phase_nxt = PH_4;
          end
          PH_4: begin
            ax3_nxt   = {byte_in[6:0], 1'b0};
            phase_nxt = PH_5;
          end
          PH_5: begin
            ax3_nxt   = ax3_r + {7'b0000000, byte_in[0]};
            phase_nxt = PH_WAIT;
            pkt_done  = 1'b1;
          end
          default: begin
            phase_nxt = PH_WAIT;
            if (start_bit) begin
              btn_nxt   = byte_in[6:3];
              ax0_nxt   = {byte_in[2:0], 5'b00000};
              phase_nxt = PH_1;
            end
          end
        endcase
      end
    end
  end

  // first two axes are inverted
  always_comb begin
    pkt.buttons = btn_r;
    pkt.raw[0]  = ~ax0_r;
    pkt.raw[1]  = ~ax1_r;
    pkt.raw[2]  = ax2_r;
    pkt.raw[3]  = ax3_r + {7'b0000000, byte_in[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      ax0_r   <= '0;
      ax1_r   <= '0;
      ax2_r   <= '0;
      ax3_r   <= '0;
      btn_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ax0_r   <= ax0_nxt;
      ax1_r   <= ax1_nxt;
      ax2_r   <= ax2_nxt;
      ax3_r   <= ax3_nxt;
      btn_r   <= btn_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/gpd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Computes (num * 2^(QW-8) + den) / (2 * den); depends on gpd_pkg for div_req_t.
`default_nettype none

module gpd_div #(
  parameter int unsigned QW = 23
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gpd_pkg::div_req_t req,
  output logic                  done,
  output logic [QW-1:0]         quo
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [8:0]    rem_r, rem_nxt;
  logic [8:0]    dsr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [9:0]    trial;
  logic [9:0]    diff;
  logic          ge;

  assign trial = {rem_r, dvd_r[QW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = {req.num_mag, (QW-8)'(req.den_mag)};
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QW-2:0], ge};
      rem_nxt = ge ? diff[8:0] : trial[8:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dsr_r <= {req.den_mag, 1'b0};
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;

endmodule

`default_nettype wire

>>> src/gameport_packet_decode_normalize.sv
// After the last packet word, each axis passes ST_SETUP and, if calibration is on and its
// divisor is nonzero, the divider in ST_DIV; ST_DONE then raises out_valid.
// Words are taken one per cycle; in_ready is low from the last word until its result loads.
// Each packet is six words, and normalizing it holds off the words of the next packet.
// Reset (rst_n, synchronous): packet state, calibration enable and out_valid cleared,
// calibration at min 0, home 0x80, max 0xFF. Depends on gpd_pkg, gpd_decoder, gpd_div.
`default_nettype none

module gameport_packet_decode_normalize #(
  parameter int unsigned FRACTION_BITS = 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_serial_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_raw_x1,
  output logic [7:0]                           out_raw_y1,
  output logic [7:0]                           out_raw_x2,
  output logic [7:0]                           out_raw_y2,
  output logic [3:0]                           out_button_bits,
  output logic signed [15:0]                   out_norm_x1,
  output logic signed [15:0]                   out_norm_y1,
  output logic signed [15:0]                   out_norm_x2,
  output logic signed [15:0]                   out_norm_y2,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpd_pkg::CAL_W-1:0]       cfg_data
);

  localparam int unsigned QW = FRACTION_BITS + 9;
  localparam int unsigned RW = FRACTION_BITS + 18;
  localparam logic [QW-1:0]        TWO_Q = QW'(2) << FRACTION_BITS;
  localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRACTION_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [1:0]                          idx_r, idx_nxt;
  logic                                cal_valid_r;
  logic [3:0][gpd_pkg::CAL_W-1:0]      cal_r;
  gpd_pkg::packet_t                    pkt_r;
  logic [3:0][15:0]                    res_r;
  logic                                out_valid_r;

  logic                                in_accept;
  logic                                cfg_accept;
  gpd_pkg::packet_t                    dec_pkt;
  logic                                dec_done;
  gpd_pkg::div_req_t                   div_req;
  logic                                div_done;
  logic [QW-1:0]                       div_q;

  logic [7:0]                          ax_v, ax_lo, ax_hm, ax_hi;
  logic                                fwd, low_br, neg;
  logic signed [8:0]                   num_s, den_s;
  logic [7:0]                          num_mag, den_mag;
  logic [QW-1:0]                       q_c;
  logic signed [RW-1:0]                q_s, sq, r_val, r_sat;
  logic [15:0]                         res_val;
  logic                                res_store;
  logic                                out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_ready;

  gpd_decoder u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .byte_in     (in_serial_byte),
    .pkt         (dec_pkt),
    .pkt_done    (dec_done)
  );

  // per-axis setup: pick branch, signed numerator and denominator
  assign ax_v  = pkt_r.raw[idx_r];
  assign ax_lo = cal_r[idx_r][23:16];
  assign ax_hm = cal_r[idx_r][15:8];
  assign ax_hi = cal_r[idx_r][7:0];
  assign fwd   = ax_lo < ax_hi;

  always_comb begin
    if (fwd) begin
      low_br = ax_v <= ax_hm;
      num_s  = low_br ? $signed({1'b0, ax_v}) - $signed({1'b0, ax_lo})
                      : $signed({1'b0, ax_v}) - $signed({1'b0, ax_hm});
      den_s  = low_br ? $signed({1'b0, ax_hm}) - $signed({1'b0, ax_lo})
                      : $signed({1'b0, ax_hi}) - $signed({1'b0, ax_hm});
    end else begin
      low_br = ax_v >= ax_hm;
      num_s  = low_br ? $signed({1'b0, ax_lo}) - $signed({1'b0, ax_v})
                      : $signed({1'b0, ax_hm}) - $signed({1'b0, ax_v});
      den_s  = low_br ? $signed({1'b0, ax_lo}) - $signed({1'b0, ax_hm})
                      : $signed({1'b0, ax_hm}) - $signed({1'b0, ax_hi});
    end
  end

  assign neg     = num_s[8] ^ den_s[8];
  assign num_mag = num_s[8] ? 8'(-num_s) : num_s[7:0];
  assign den_mag = den_s[8] ? 8'(-den_s) : den_s[7:0];

  assign div_req.start   = (state_r == ST_SETUP) && cal_valid_r && (den_mag != 8'd0);
  assign div_req.num_mag = num_mag;
  assign div_req.den_mag = den_mag;

  gpd_div #(
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_q)
  );

  // sign, offset and saturate the rounded quotient
  assign q_c   = (div_q > TWO_Q) ? TWO_Q : div_q;
  assign q_s   = RW'(q_c);
  assign sq    = neg ? -q_s : q_s;
  assign r_val = low_br ? sq - ONE_R : sq;
  assign r_sat = (r_val < -ONE_R) ? -ONE_R : ((r_val > ONE_R) ? ONE_R : r_val);

  always_comb begin
    if (!cal_valid_r) begin
      res_val = '0;
    end else if (den_mag == 8'd0) begin
      res_val = low_br ? 16'((-ONE_R)) : 16'(ONE_R);
    end else begin
      res_val = r_sat[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    res_store = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && dec_done) begin
          state_nxt = ST_SETUP;
          idx_nxt   = 2'd0;
        end
      end
      ST_SETUP: begin
        if (div_req.start) begin
          state_nxt = ST_DIV;
        end else begin
          res_store = 1'b1;
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? ST_DONE : ST_SETUP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_store = 1'b1;
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? ST_DONE : ST_SETUP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
      cal_valid_r <= 1'b0;
      cal_r       <= {gpd_pkg::AXES{gpd_pkg::CAL_RESET}};
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_accept) begin
        case (cfg_index)
          gpd_pkg::REG_CAL_VALID: cal_valid_r <= cfg_data[0];
          gpd_pkg::REG_X1_CAL:    cal_r[0]    <= cfg_data;
          gpd_pkg::REG_Y1_CAL:    cal_r[1]    <= cfg_data;
          gpd_pkg::REG_X2_CAL:    cal_r[2]    <= cfg_data;
          gpd_pkg::REG_Y2_CAL:    cal_r[3]    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && dec_done) begin
      pkt_r <= dec_pkt;
    end
    if (res_store) begin
      res_r[idx_r] <= res_val;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_raw_x1      <= pkt_r.raw[0];
      out_raw_y1      <= pkt_r.raw[1];
      out_raw_x2      <= pkt_r.raw[2];
      out_raw_y2      <= pkt_r.raw[3];
      out_button_bits <= pkt_r.buttons;
      out_norm_x1     <= res_r[0];
      out_norm_y1     <= res_r[1];
      out_norm_x2     <= res_r[2];
      out_norm_y2     <= res_r[3];
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside of divide state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word raised without finishing normalize");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((FRACTION_BITS > 14) ||
      (($signed(out_norm_x1) <= $signed(16'(ONE_R))) &&
       ($signed(out_norm_x1) >= -$signed(16'(ONE_R))))))
    else $error("normalized first axis out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for gameport_packet_decode_normalize: directed packets, then random
// byte streams checked word by word against an in-bench packet decoder and normalizer.
// Depends on gpd_pkg and the RTL of the block only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [gpd_pkg::CFG_IDX_W-1:0] reg_idx_t;
  typedef logic [gpd_pkg::CAL_W-1:0]     cal_word_t;

  localparam int FRAC = 14;
  localparam int ONE = 1 << FRAC;
  localparam int DRAIN_CYCLES = 4 * (FRAC + 11) + 20;
  localparam int HOLD_CYCLES = 1500;
  localparam int RAND_PHASES = 10;
  localparam int PACKETS_PER_PHASE = 28;
  localparam reg_idx_t REG_NONE = gpd_pkg::REG_Y2_CAL + 3'd1;
  localparam reg_idx_t AXIS_REG [4] = '{gpd_pkg::REG_X1_CAL, gpd_pkg::REG_Y1_CAL,
                                         gpd_pkg::REG_X2_CAL, gpd_pkg::REG_Y2_CAL};

  typedef struct packed {
    logic [3:0][7:0]  raw;
    logic [3:0]       buttons;
    logic [3:0][15:0] norm;
  } joy_report_t;

  typedef struct packed {
    bit                   is_cfg;
    reg_idx_t             idx;
    cal_word_t            data;
    logic [7:0]           word;
    bit                   typed;
    joy_report_t          want;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [7:0] in_serial_byte;
  logic out_valid, out_ready;
  logic [7:0] out_raw_x1, out_raw_y1, out_raw_x2, out_raw_y2;
  logic [3:0] out_button_bits;
  logic signed [15:0] out_norm_x1, out_norm_y1, out_norm_x2, out_norm_y2;
  logic cfg_valid, cfg_ready;
  reg_idx_t cfg_index;
  cal_word_t cfg_data;

  gameport_packet_decode_normalize u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_serial_byte(in_serial_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_raw_x1(out_raw_x1), .out_raw_y1(out_raw_y1),
    .out_raw_x2(out_raw_x2), .out_raw_y2(out_raw_y2),
    .out_button_bits(out_button_bits),
    .out_norm_x1(out_norm_x1), .out_norm_y1(out_norm_y1),
    .out_norm_x2(out_norm_x2), .out_norm_y2(out_norm_y2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // decoder model state
  int         pkt_phase;
  logic [7:0] acc [4];
  logic [3:0] acc_buttons;
  bit         cal_on;
  cal_word_t  cal [4];

  joy_report_t pending_reports [$];
  stim_row_t   dir_rows [$];
  int  mismatches;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic logic [15:0] norm_axis(input logic [7:0] v, input cal_word_t c);
    int lo, hm, hi, x, num, den, an, ad, q, r;
    bit low;
    lo = int'(c[23:16]);
    hm = int'(c[15:8]);
    hi = int'(c[7:0]);
    x = int'(v);
    if (lo < hi) begin
      if (x <= hm) begin
        num = x - lo; den = hm - lo; low = 1;
      end else begin
        num = x - hm; den = hi - hm; low = 0;
      end
    end else begin
      if (x >= hm) begin
        num = lo - x; den = lo - hm; low = 1;
      end else begin
        num = hm - x; den = hm - hi; low = 0;
      end
    end
    if (den == 0) begin
      r = low ? -ONE : ONE;
    end else begin
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = ((an << (FRAC + 1)) + ad) / (2 * ad);
      r = ((num < 0) != (den < 0)) ? -q : q;
      if (low) r -= ONE;
      if (r < -ONE) r = -ONE;
      if (r > ONE) r = ONE;
    end
    return r[15:0];
  endfunction

  function automatic joy_report_t report_of(input logic [7:0] x1, y1, x2, y2,
                                            input logic [3:0] btn,
                                            input logic [15:0] nx1, ny1, nx2, ny2);
    joy_report_t r;
    r.raw = '{y2, x2, y1, x1};
    r.buttons = btn;
    r.norm = '{ny2, nx2, ny1, nx1};
    return r;
  endfunction

  task automatic reset_model();
    pkt_phase = 0;
    foreach (acc[i]) acc[i] = '0;
    acc_buttons = '0;
    cal_on = 0;
    foreach (cal[i]) cal[i] = gpd_pkg::CAL_RESET;
  endtask

  task automatic decode_word(input logic [7:0] b, output bit done, output joy_report_t r);
    done = 0;
    r = '0;
    if (pkt_phase >= 1 && pkt_phase <= 5 && b[7]) begin
      pkt_phase = 0;
    end else begin
      case (pkt_phase)
        1: begin
          acc[0] = acc[0] + {3'b000, b[6:2]};
          acc[1] = {b[1:0], 6'b0};
          pkt_phase = 2;
        end
        2: begin
          acc[1] = acc[1] + {2'b00, b[6:1]};
          acc[2] = {b[0], 7'b0};
          pkt_phase = 3;
        end
        3: begin
          acc[2] = acc[2] + {1'b0, b[6:0]};
          pkt_phase = 4;
        end
        4: begin
          acc[3] = {b[6:0], 1'b0};
          pkt_phase = 5;
        end
        5: begin
          acc[3] = acc[3] + {7'b0000000, b[0]};
          pkt_phase = 0;
          r.raw[0] = 8'hFF - acc[0];
          r.raw[1] = 8'hFF - acc[1];
          r.raw[2] = acc[2];
          r.raw[3] = acc[3];
          r.buttons = acc_buttons;
          for (int i = 0; i < 4; i++)
            r.norm[i] = cal_on ? norm_axis(r.raw[i], cal[i]) : 16'h0000;
          done = 1;
        end
        default: begin
          pkt_phase = 0;
          if (b[7]) begin
            acc_buttons = b[6:3];
            acc[0] = {b[2:0], 5'b0};
            pkt_phase = 1;
          end
        end
      endcase
    end
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid <= 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_word(input logic [7:0] b, input bit typed = 0,
                           input joy_report_t want = '0);
    bit done;
    joy_report_t r;
    if (burst_left == 0) begin
      if (gaps_on) idle_input($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1;
    in_serial_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_word(b, done, r);
    if (done) pending_reports.push_back(typed ? want : r);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input cal_word_t d);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gpd_pkg::REG_CAL_VALID: cal_on = d[0];
      gpd_pkg::REG_X1_CAL:    cal[0] = d;
      gpd_pkg::REG_Y1_CAL:    cal[1] = d;
      gpd_pkg::REG_X2_CAL:    cal[2] = d;
      gpd_pkg::REG_Y2_CAL:    cal[3] = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // quiet input, all results in, then let the divider finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cal_word_t pick_cal();
    logic [7:0] p, q, s, t;
    p = 8'($urandom); q = 8'($urandom); s = 8'($urandom);
    if (p > q) begin t = p; p = q; q = t; end
    if (q > s) begin t = q; q = s; s = t; end
    if (p > q) begin t = p; p = q; q = t; end
    case ($urandom_range(0, 6))
      0: return gpd_pkg::CAL_RESET;
      1: return 24'hFF8000;
      2, 3: return {p, q, s};
      4: return {s, q, p};
      5: return $urandom_range(0, 1) ? {p, p, s} : {p, s, s};
      default: return cal_word_t'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.word = b;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] b, input joy_report_t want);
    stim_row_t row;
    row = '0;
    row.word = b;
    row.typed = 1;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input reg_idx_t idx, input cal_word_t d);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1;
    row.idx = idx;
    row.data = d;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin : watch_results
    joy_report_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = report_of(out_raw_x1, out_raw_y1, out_raw_x2, out_raw_y2, out_button_bits,
                       out_norm_x1, out_norm_y1, out_norm_x2, out_norm_y2);
      if (pending_reports.size() == 0) begin
        flag_mismatch("word with nothing pending, raw_x1", int'(seen.raw[0]), 0);
      end else begin
        want = pending_reports.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (seen.raw[i] !== want.raw[i])
            flag_mismatch($sformatf("raw[%0d]", i), int'(seen.raw[i]), int'(want.raw[i]));
          if (seen.norm[i] !== want.norm[i])
            flag_mismatch($sformatf("norm[%0d]", i), int'(seen.norm[i]),
                          int'(want.norm[i]));
        end
        if (seen.buttons !== want.buttons)
          flag_mismatch("button_bits", int'(seen.buttons), int'(want.buttons));
      end
    end
  end

  initial begin : receiver
    int cyc, mode;
    bit held;
    cyc = 0;
    mode = 0;
    held = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1;
      end else begin
        cyc++;
        if (cyc % 256 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 9) > 2;
        endcase
      end
    end
  end

  initial begin : stimulus
    int n;
    cal_word_t c;
    rst_n = 0;
    in_valid = 0;
    in_serial_byte = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    burst_left = 0;
    gaps_on = 1;
    hold_req = 0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // calibration off: all-zero packet
    add_word(8'h80);
    repeat (4) add_word(8'h00);
    add_typed(8'h00, report_of(8'hFF, 8'hFF, 8'h00, 8'h00, 4'h0,
                               16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // reset calibration, forward stick at both ends
    add_cfg(gpd_pkg::REG_CAL_VALID, 24'h000001);
    add_word(8'h80);
    repeat (4) add_word(8'h00);
    add_typed(8'h00, report_of(8'hFF, 8'hFF, 8'h00, 8'h00, 4'h0,
                               16'h4000, 16'h4000, 16'hC000, 16'hC000));
    // min = home = max: zero denominators, unused register index
    foreach (AXIS_REG[i]) add_cfg(AXIS_REG[i], 24'h808080);
    add_cfg(REG_NONE, 24'hFFFFFF);
    add_word(8'hFF);
    repeat (4) add_word(8'h7F);
    add_typed(8'h7F, report_of(8'h00, 8'h00, 8'hFF, 8'hFF, 4'hF,
                               16'h4000, 16'h4000, 16'hC000, 16'hC000));
    // data while waiting, aborted packet, then a mixed packet
    add_word(8'h55);
    add_word(8'h9A);
    add_word(8'h33);
    add_word(8'hC4);
    add_cfg(gpd_pkg::REG_X1_CAL, 24'hFF8000);
    add_cfg(gpd_pkg::REG_Y1_CAL, 24'h10C0F0);
    add_cfg(gpd_pkg::REG_X2_CAL, 24'h000000);
    add_word(8'hB5);
    add_word(8'h2A);
    add_word(8'h51);
    add_word(8'h7E);
    add_word(8'h03);
    add_word(8'h01);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      cfg_write(gpd_pkg::REG_CAL_VALID,
                (ph == 3) ? 24'h0 : (ph == 6) ? cal_word_t'($urandom) : 24'h1);
      foreach (AXIS_REG[a]) begin
        c = (ph == 0) ? 24'h000000 : (ph == RAND_PHASES - 1) ? 24'hFFFFFF : pick_cal();
        cfg_write(AXIS_REG[a], c);
      end
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_NONE + reg_idx_t'($urandom_range(0, 2)), cal_word_t'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (ph == 1) hold_req = 1;
      for (int k = 0; k < PACKETS_PER_PHASE; k++) begin
        n = $urandom_range(0, 99);
        if (n < 85) begin
          send_word(8'h80 | 8'($urandom_range(0, 127)));
          repeat (5) send_word(8'($urandom_range(0, 127)));
        end else if (n < 93) begin
          send_word(8'h80 | 8'($urandom_range(0, 127)));
          repeat ($urandom_range(0, 4)) send_word(8'($urandom_range(0, 127)));
          send_word(8'h80 | 8'($urandom_range(0, 127)));
        end else begin
          repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
